// ===== sv/mma_pkg.sv =====
// Shared types and constants for the multichannel moving average block.
// No dependencies; used by mma_div and multichannel_moving_average.
package mma_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int OP_W     = 2;
  localparam int MAX_OUT  = 4;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [OP_W-1:0]     op_t;

  localparam op_t OP_SAMPLE   = 2'd0;
  localparam op_t OP_READ     = 2'd1;
  localparam op_t OP_READ_ALL = 2'd2;

endpackage

// ===== sv/mma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module mma_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/mma_div.sv =====
// Divide a running sum by the window length: reciprocal multiply, registered.
// Depends on mma_pkg for the sum and sample widths.
module mma_div #(
  parameter int WINDOW = 10
) (
  input  logic            clk,
  input  logic            load,
  input  mma_pkg::sum_t   sum,
  output mma_pkg::sample_t quot
);

  // floor(n / W) == (n * ceil(2^(N+L) / W)) >> (N+L) for every N-bit n
  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SH     = mma_pkg::SUM_W + LOG_W;
  localparam int RCP_W  = mma_pkg::SUM_W + 2;
  localparam int PROD_W = mma_pkg::SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(sum) * PROD_W'(RECIP);
    end
  end

  assign quot = prod_r[SH +: mma_pkg::SAMPLE_W];

endmodule

// ===== sv/multichannel_moving_average.sv =====
// Top level: round-robin multichannel boxcar averager with a window RAM.
// Depends on mma_pkg, mma_ram and mma_div.
//
//  channel | ports                                            | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_ready, in_operation, in_sample,     | in
//          | in_read_channel                                  |
//  out     | out_valid, out_ready, out_channel, out_average,  | out
//          | out_adc_select, out_last                         |
//
// From transfer to result load, a new sample passes one window RAM read, a
// subtract and an add on the shared add/sub unit, one reciprocal multiply
// and the average write-back. A single read goes straight to its result load;
// read-all loads one result per cycle while the output register is free.
// One item is in work at a time; the next enters the cycle after the last load.
// Reset (synchronous, active low) clears pointers, sums, averages and the
// per-entry valid bits of the window RAM; an invalid entry reads as zero.
// A stalled output holds its register; the emit step waits for it to free.
module multichannel_moving_average #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mma_pkg::op_t           in_operation,
  input  mma_pkg::sample_t       in_sample,
  input  logic [1:0]             in_read_channel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_channel,
  output mma_pkg::sample_t       out_average,
  output logic [1:0]             out_adc_select,
  output logic                   out_last
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW    = (CW > 2) ? CW : 2;      // report-select width
  localparam int SLW   = $clog2(WINDOW);
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int NREAD = (CHANNELS < mma_pkg::MAX_OUT) ? CHANNELS : mma_pkg::MAX_OUT;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;   // sum - oldest, write new sample
  localparam logic [2:0] S_ADD  = 3'd2;   // + new sample, store sum
  localparam logic [2:0] S_MUL  = 3'd3;   // reciprocal multiply
  localparam logic [2:0] S_DIV  = 3'd4;   // store average, advance pointers
  localparam logic [2:0] S_EMIT = 3'd5;   // load result register(s)

  logic [2:0]             state_r, state_nxt;
  logic [CW-1:0]          ch_ptr_r, ch_ptr_nxt;
  logic [SLW-1:0]         slot_ptr_r, slot_ptr_nxt;
  mma_pkg::sum_t          sum_r [CHANNELS];
  mma_pkg::sum_t          sum_nxt [CHANNELS];
  mma_pkg::sample_t       avg_r [CHANNELS];
  mma_pkg::sample_t       avg_nxt [CHANNELS];
  logic [DEPTH-1:0]       vld_r, vld_nxt;
  logic                   old_vld_r, old_vld_nxt;
  mma_pkg::sample_t       smp_r, smp_nxt;
  mma_pkg::sum_t          acc_r, acc_nxt;
  logic [SW-1:0]          sel_r, sel_nxt;
  logic                   all_r, all_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_channel_r, out_channel_nxt;
  mma_pkg::sample_t       out_average_r, out_average_nxt;
  logic [1:0]             out_adc_r, out_adc_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [AW-1:0]          addr;
  mma_pkg::sample_t       ram_rdata;
  logic                   ram_we;
  mma_pkg::sample_t       quot;
  logic                   div_load;

  // shared add/sub unit
  mma_pkg::sum_t          alu_a, alu_b, alu_y;
  logic                   alu_sub;

  mma_pkg::sample_t       sel_avg;
  logic                   sel_last;
  logic                   out_free;
  logic                   in_xfer;

  // window slot of the current channel
  assign addr = AW'(ch_ptr_r * WINDOW + slot_ptr_r);

  mma_ram #(
    .WIDTH (mma_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (smp_r),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  mma_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk  (clk),
    .load (div_load),
    .sum  (acc_r),
    .quot (quot)
  );

  assign ram_we   = (state_r == S_SUB);
  assign div_load = (state_r == S_MUL);
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    alu_sub = (state_r == S_SUB);
    if (state_r == S_SUB) begin
      alu_a = sum_r[ch_ptr_r];
      alu_b = old_vld_r ? mma_pkg::SUM_W'(ram_rdata) : '0;
    end else begin
      alu_a = acc_r;
      alu_b = mma_pkg::SUM_W'(smp_r);
    end
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // channel being reported; out-of-range channels read as zero
  always_comb begin
    sel_avg  = (int'(sel_r) < CHANNELS) ? avg_r[sel_r[CW-1:0]] : '0;
    sel_last = !all_r || (sel_r == SW'(NREAD - 1));
  end

  always_comb begin
    state_nxt       = state_r;
    ch_ptr_nxt      = ch_ptr_r;
    slot_ptr_nxt    = slot_ptr_r;
    sum_nxt         = sum_r;
    avg_nxt         = avg_r;
    vld_nxt         = vld_r;
    old_vld_nxt     = old_vld_r;
    smp_nxt         = smp_r;
    acc_nxt         = acc_r;
    sel_nxt         = sel_r;
    all_nxt         = all_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_channel_nxt = out_channel_r;
    out_average_nxt = out_average_r;
    out_adc_nxt     = out_adc_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_operation)
            mma_pkg::OP_SAMPLE: begin
              // RAM read of the oldest sample is issued this cycle
              old_vld_nxt = vld_r[addr];
              smp_nxt     = in_sample;
              state_nxt   = S_SUB;
            end
            mma_pkg::OP_READ: begin
              sel_nxt   = SW'(in_read_channel);
              all_nxt   = 1'b0;
              state_nxt = S_EMIT;
            end
            mma_pkg::OP_READ_ALL: begin
              sel_nxt   = '0;
              all_nxt   = 1'b1;
              state_nxt = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;   // unused code: dropped
            end
          endcase
        end
      end
      S_SUB: begin
        acc_nxt       = alu_y;
        vld_nxt[addr] = 1'b1;
        state_nxt     = S_ADD;
      end
      S_ADD: begin
        acc_nxt           = alu_y;
        sum_nxt[ch_ptr_r] = alu_y;
        state_nxt         = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        avg_nxt[ch_ptr_r] = quot;
        sel_nxt           = SW'(ch_ptr_r);
        all_nxt           = 1'b0;
        if (ch_ptr_r == CW'(CHANNELS - 1)) begin
          ch_ptr_nxt   = '0;
          slot_ptr_nxt = (slot_ptr_r == SLW'(WINDOW - 1)) ? '0 : slot_ptr_r + 1'b1;
        end else begin
          ch_ptr_nxt = ch_ptr_r + 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_channel_nxt = 2'(sel_r);
          out_average_nxt = sel_avg;
          out_adc_nxt     = 2'(ch_ptr_r);
          out_last_nxt    = sel_last;
          if (sel_last) begin
            state_nxt = S_IDLE;
          end else begin
            sel_nxt = sel_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_ptr_r    <= '0;
      slot_ptr_r  <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i] <= '0;
        avg_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ch_ptr_r    <= ch_ptr_nxt;
      slot_ptr_r  <= slot_ptr_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      avg_r       <= avg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    old_vld_r     <= old_vld_nxt;
    smp_r         <= smp_nxt;
    acc_r         <= acc_nxt;
    sel_r         <= sel_nxt;
    all_r         <= all_nxt;
    out_channel_r <= out_channel_nxt;
    out_average_r <= out_average_nxt;
    out_adc_r     <= out_adc_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_channel_r;
  assign out_average    = out_average_r;
  assign out_adc_select = out_adc_r;
  assign out_last       = out_last_r;

endmodule

// ===== tb/sv/tb_multichannel_moving_average.sv =====
// Self-checking testbench for multichannel_moving_average: random-gap driver, stalling
// receiver and an item-level average predictor compared field by field per transfer.
// Depends on mma_pkg and the RTL of multichannel_moving_average.
module tb_multichannel_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH         = 4;
  localparam int WIN        = 10;
  localparam int IDLE_PCT   = 22;
  localparam int HOLD_LEN   = 120;     // long receiver hold-off, in cycles
  localparam int HOLD_AT    = 60;      // input transfers before the hold-off starts
  localparam int CALM_LO    = 150;     // no idling on either side between these
  localparam int CALM_HI    = 230;     // two input transfer counts
  localparam int TAIL       = 40;      // settle time after the last result
  localparam int CYCLE_CAP  = 200000;

  // one pending input transfer; drain makes the sender wait for all results first
  typedef struct {
    mma_pkg::op_t     op;
    mma_pkg::sample_t smp;
    logic [1:0]       rch;
    bit               drain;
  } stim_item_t;

  typedef struct {
    logic [1:0]       channel;
    mma_pkg::sample_t average;
    logic [1:0]       adc_select;
    logic             last;
  } avg_result_t;

  logic             clk;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_ready;
  mma_pkg::op_t     in_operation    = mma_pkg::OP_SAMPLE;
  mma_pkg::sample_t in_sample       = '0;
  logic [1:0]       in_read_channel = 2'd0;
  logic             out_valid;
  logic             out_ready       = 1'b0;
  logic [1:0]       out_channel;
  mma_pkg::sample_t out_average;
  logic [1:0]       out_adc_select;
  logic             out_last;

  multichannel_moving_average #(
    .CHANNELS(CH),
    .WINDOW  (WIN)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_sample      (in_sample),
    .in_read_channel(in_read_channel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_average    (out_average),
    .out_adc_select (out_adc_select),
    .out_last       (out_last)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  stim_item_t  pending_q[$];
  avg_result_t avg_expect_q[$];

  int sent_cnt  = 0;   // accepted input transfers (driver, nonblocking)
  int due_cnt   = 0;   // results predicted so far (driver only)
  int got_cnt   = 0;   // results accepted (monitor, nonblocking)
  int err_cnt   = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Predictor state: window contents, running sums, latest averages and the
  // two round-robin pointers, all cleared like the block at reset.
  mma_pkg::sample_t win_mem[CH*WIN];
  mma_pkg::sum_t    win_sum[CH];
  mma_pkg::sample_t ch_avg[CH];
  logic [1:0]       cur_ch   = '0;
  int               cur_slot = 0;

  initial begin
    foreach (win_mem[i]) win_mem[i] = '0;
    foreach (win_sum[i]) win_sum[i] = '0;
    foreach (ch_avg[i])  ch_avg[i]  = '0;
  end

  // True inside the stretch where neither side idles.
  function automatic bit calm_window();
    return sent_cnt >= CALM_LO && sent_cnt < CALM_HI;
  endfunction

  function automatic void push_avg(logic [1:0] chan, mma_pkg::sample_t avg, logic lst);
    avg_result_t r;
    r.channel    = chan;
    r.average    = avg;
    r.adc_select = cur_ch;     // pointer after this item
    r.last       = lst;
    avg_expect_q.push_back(r);
    due_cnt++;
  endfunction

  // Advance the filter state for one accepted item and queue what it yields.
  function automatic void predict_averages(mma_pkg::op_t op, mma_pkg::sample_t smp,
                                           logic [1:0] rch);
    int            idx;
    mma_pkg::sum_t sum;
    logic [1:0]    chan;
    chan = cur_ch;
    case (op)
      mma_pkg::OP_SAMPLE: begin
        idx = int'(chan) * WIN + cur_slot;
        // replace the oldest sample of this slot; the sum never wraps
        sum = win_sum[chan] - mma_pkg::sum_t'(win_mem[idx]) + mma_pkg::sum_t'(smp);
        win_mem[idx]  = smp;
        win_sum[chan] = sum;
        ch_avg[chan]  = mma_pkg::sample_t'(sum / WIN);
        if (int'(chan) == CH - 1) begin
          cur_ch   = '0;
          cur_slot = (cur_slot == WIN - 1) ? 0 : cur_slot + 1;
        end else begin
          cur_ch = chan + 2'd1;
        end
        push_avg(chan, ch_avg[chan], 1'b1);
      end
      mma_pkg::OP_READ: begin
        push_avg(rch, (int'(rch) < CH) ? ch_avg[rch] : mma_pkg::sample_t'(0), 1'b1);
      end
      mma_pkg::OP_READ_ALL: begin
        for (int k = 0; k < CH && k < mma_pkg::MAX_OUT; k++)
          push_avg(2'(k), ch_avg[k], (k == CH - 1) || (k == mma_pkg::MAX_OUT - 1));
      end
      default: ;               // unused code: ignored, nothing comes back
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("mismatch at cycle %0d: %s got %0d expected %0d",
             cycle_cnt, what, got_v, want_v);
    err_cnt++;
  endtask

  function automatic void add_item(mma_pkg::op_t op, mma_pkg::sample_t smp, logic [1:0] rch,
                                   bit drain = 1'b0);
    stim_item_t it;
    it.op    = op;
    it.smp   = smp;
    it.rch   = rch;
    it.drain = drain;
    pending_q.push_back(it);
  endfunction

  function automatic mma_pkg::sample_t rand_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8)  return '0;
    if (pick < 16) return '1;
    return mma_pkg::sample_t'($urandom_range(4095));
  endfunction

  // Driver: presents the next queued item when the slot is free, idling at
  // random. An item marked drain is held back until every result is in.
  always @(posedge clk) begin : drive_proc
    stim_item_t nxt;
    bit         idle;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_operation    <= mma_pkg::OP_SAMPLE;
      in_sample       <= '0;
      in_read_channel <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_averages(in_operation, in_sample, in_read_channel);
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        idle = !calm_window() && ($urandom_range(99) < IDLE_PCT);
        if (pending_q.size() != 0 && !idle &&
            !(pending_q[0].drain && due_cnt != got_cnt)) begin
          nxt = pending_q.pop_front();
          in_valid        <= 1'b1;
          in_operation    <= nxt.op;
          in_sample       <= nxt.smp;
          in_read_channel <= nxt.rch;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once the sender is well under way.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready: random stalls, none in the calm stretch; forced low
  // while the hold-off runs down.
  always @(posedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= (hold_left == 0) &&
                   (calm_window() || $urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin : check_proc
    avg_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got_cnt <= got_cnt + 1;
      if (avg_expect_q.size() == 0) begin
        report_mismatch("unexpected result, channel", out_channel, -1);
      end else begin
        want = avg_expect_q.pop_front();
        if (out_channel !== want.channel)
          report_mismatch("channel", out_channel, want.channel);
        if (out_average !== want.average)
          report_mismatch("average", out_average, want.average);
        if (out_adc_select !== want.adc_select)
          report_mismatch("adc_select", out_adc_select, want.adc_select);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int counted;
    int pick;

    // Directed: reads of the cleared store, the unused code, a full-scale sample
    // on every channel and a zero sample, then reads of each channel and read-all.
    add_item(mma_pkg::OP_READ, '0, 2'd0);
    add_item(mma_pkg::OP_READ, '1, 2'd3);
    add_item(mma_pkg::OP_READ_ALL, '0, 2'd0);
    add_item(mma_pkg::op_t'(2'd3), '1, 2'd3);
    repeat (4) add_item(mma_pkg::OP_SAMPLE, '1, 2'd0);
    add_item(mma_pkg::OP_SAMPLE, '0, 2'd3);
    add_item(mma_pkg::OP_SAMPLE, 12'd1, 2'd1);
    add_item(mma_pkg::OP_SAMPLE, 12'hAAA, 2'd2);
    add_item(mma_pkg::OP_SAMPLE, 12'h555, 2'd1);
    for (int c = 0; c < CH; c++) add_item(mma_pkg::OP_READ, 12'hFFF, 2'(c));
    add_item(mma_pkg::OP_READ_ALL, '1, 2'd3);
    add_item(mma_pkg::op_t'(2'd3), '0, 2'd0);
    repeat (4) add_item(mma_pkg::OP_SAMPLE, '1, 2'd2);
    add_item(mma_pkg::OP_READ_ALL, 12'h800, 2'd1);
    add_item(mma_pkg::OP_READ, 12'h7FF, 2'd2);
    counted = 23;

    // Random: mostly samples so the windows roll over many times, with reads mixed
    // in; two bursts fill every channel's window, once at full scale, once at zero.
    while (counted < 330) begin
      if (counted == 24 || counted == 250) begin
        add_item(mma_pkg::OP_READ_ALL, rand_sample(), 2'($urandom_range(3)), 1'b1);
        counted++;
      end else if (counted == 90 || counted == 180) begin
        repeat (CH * WIN)
          add_item(mma_pkg::OP_SAMPLE, (counted == 90) ? 12'hFFF : 12'h000,
                   2'($urandom_range(3)));
        add_item(mma_pkg::OP_READ_ALL, rand_sample(), 2'($urandom_range(3)));
        counted += CH * WIN + 1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          add_item(mma_pkg::OP_SAMPLE, rand_sample(), 2'($urandom_range(3)));
          counted++;
        end else if (pick < 85) begin
          add_item(mma_pkg::OP_READ, rand_sample(), 2'($urandom_range(3)));
          counted++;
        end else if (pick < 95) begin
          add_item(mma_pkg::OP_READ_ALL, rand_sample(), 2'($urandom_range(3)));
          counted++;
        end else begin
          // ignored code: does not count toward the item total
          add_item(mma_pkg::op_t'(2'd3), rand_sample(), 2'($urandom_range(3)));
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sample at the falling edge so the driver's updates have settled
    while (pending_q.size() != 0 || in_valid) @(negedge clk);
    while (got_cnt != due_cnt) @(negedge clk);
    repeat (TAIL) @(negedge clk);

    if (avg_expect_q.size() != 0)
      report_mismatch("results still outstanding", 0, avg_expect_q.size());

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
